// ===== sv/rvz_pkg.sv =====
// Shared types and reset constants of the rolling VWAP z-score stop.
package rvz_pkg;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic [5:0]  lookback;
        logic [15:0] threshold;
    } cfg_t;

    // One input candle.
    typedef struct packed {
        logic [31:0]        high;
        logic [31:0]        low;
        logic [31:0]        close;
        logic [31:0]        volume;
        logic signed [31:0] position;
    } candle_t;

    // One word of the candle history memory.
    typedef struct packed {
        logic [31:0] close;
        logic [31:0] typical;
        logic [31:0] volume;
    } entry_t;

    // One result item.
    typedef struct packed {
        logic               exit_now;
        logic signed [31:0] close_qty;
    } result_t;

    localparam logic [5:0]  LOOKBACK_RST  = 6'd20;
    localparam logic [15:0] THRESHOLD_RST = 16'd512;

endpackage

// ===== sv/rvz_ring.sv =====
// Candle history memory: one write port, one read port with registered data.
module rvz_ring #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  rvz_pkg::entry_t      wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output rvz_pkg::entry_t      rdata
);

    rvz_pkg::entry_t mem [DEPTH];
    rvz_pkg::entry_t rdata_reg;

    // Write and read ports, read data registered in the cycle after the address.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/rvz_mul.sv =====
// Shift-add multiplier: one multiplier bit per cycle, stops when no set bits remain.
module rvz_mul #(
    parameter int PW = 192,
    parameter int BW = 70
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [PW-1:0] a,
    input  logic [BW-1:0] b,
    output logic          done,
    output logic [PW-1:0] product
);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [PW-1:0] a_reg, a_next;
    logic [BW-1:0] b_reg, b_next;
    logic [PW-1:0] acc_reg, acc_next;

    // Next-value logic of the add-and-shift step.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start) begin
            busy_next = 1'b1;
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
        end else if (busy_reg) begin
            if (b_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                if (b_reg[0]) begin
                    acc_next = acc_reg + a_reg;
                end
                a_next = a_reg << 1;
                b_next = b_reg >> 1;
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Operands and accumulator.
    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== sv/rvz_core.sv =====
// Stop sequencer: stores the candle, scans the window and runs the squared z-score test.
module rvz_core #(
    parameter int MAX_WINDOW = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  rvz_pkg::cfg_t     cfg,
    input  logic              start,
    input  rvz_pkg::candle_t  candle,
    output logic              ready,
    output logic              res_valid,
    input  logic              res_ready,
    output rvz_pkg::result_t  res
);

    localparam int AW     = $clog2(MAX_WINDOW);
    localparam int CW     = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = 32 + AW;
    localparam int SQ_W   = 64 + AW;
    localparam int PW     = 32 + CW + SQ_W + 2 * SUM_W + 1;
    localparam int BW     = SQ_W;
    localparam logic [AW-1:0] LAST_SLOT  = AW'(MAX_WINDOW - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_WINDOW);
    // floor(v/3) = (v * ceil(2^20/3)) >> 20 for every v below 2^19.
    localparam logic [18:0] DIV3_MUL   = 19'd349526;
    localparam int          DIV3_SHIFT = 20;
    localparam int          MIN_LOOKBACK = 2;
    localparam int          MIN_SEEN     = 3;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV_HI, ST_DIV_LO, ST_SCAN,
        ST_MUL_T, ST_MUL_U, ST_MUL_X, ST_MUL_L, ST_MUL_L2,
        ST_MUL_R, ST_MUL_R2, ST_MUL_R3, ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic                issued_reg, issued_next;
    logic [AW-1:0]       slot_reg, slot_next;
    logic [CW-1:0]       seen_reg, seen_next;
    logic                v1_reg, v1_next;
    logic                v2_reg, v2_next;

    logic [31:0]         close_reg, close_next;
    logic [31:0]         vol_reg, vol_next;
    logic signed [31:0]  pos_reg, pos_next;
    logic [33:0]         sum3_reg, sum3_next;
    logic [15:0]         q1_reg, q1_next;
    logic [1:0]          r1_reg, r1_next;
    logic [CW-1:0]       n_reg, n_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [AW-1:0]       rd_slot_reg, rd_slot_next;
    logic [31:0]         c_d_reg, c_d_next;
    logic [31:0]         v_d_reg, v_d_next;
    logic [63:0]         cc_reg, cc_next;
    logic [63:0]         tv_reg, tv_next;
    logic [SUM_W-1:0]    sum_c_reg, sum_c_next;
    logic [SUM_W-1:0]    sum_v_reg, sum_v_next;
    logic [SQ_W-1:0]     sq_reg, sq_next;
    logic [SQ_W-1:0]     pv_reg, pv_next;
    logic [PW-1:0]       big_reg, big_next;
    logic [PW-1:0]       lhs_reg, lhs_next;
    logic                fire_reg, fire_next;

    logic [18:0]         div_v;
    logic [37:0]         div_prod;
    logic [17:0]         div_q;
    logic [31:0]         typical;
    logic [CW-1:0]       seen_inc;
    logic [6:0]          lb1;
    logic [CW-1:0]       n_calc;
    logic                quiet;
    logic                scan_rd;
    logic [AW-1:0]       prev_slot;
    logic [2*CW-1:0]     nn;
    logic [31:0]         thr_sq;
    logic [PW-1:0]       pv_wide;
    logic                is_mul;
    logic                mul_start;
    logic [PW-1:0]       mul_a;
    logic [BW-1:0]       mul_b;
    logic                mul_done;
    logic [PW-1:0]       mul_p;
    logic                ring_we;
    rvz_pkg::entry_t     ring_wdata;
    rvz_pkg::entry_t     ring_rdata;

    rvz_ring #(
        .DEPTH (MAX_WINDOW),
        .AW    (AW)
    ) u_ring (
        .aclk  (aclk),
        .we    (ring_we),
        .waddr (slot_reg),
        .wdata (ring_wdata),
        .re    (scan_rd),
        .raddr (rd_slot_reg),
        .rdata (ring_rdata)
    );

    rvz_mul #(
        .PW (PW),
        .BW (BW)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    // Typical price divided by three in two 17-bit digits.
    assign div_v    = (state_reg == ST_DIV_HI) ? {2'b00, sum3_reg[33:17]}
                                               : {r1_reg, sum3_reg[16:0]};
    assign div_prod = div_v * DIV3_MUL;
    assign div_q    = div_prod[37:DIV3_SHIFT];
    assign typical  = 32'({q1_reg, div_q[16:0]});

    // Window length and the cases that never fire.
    assign seen_inc = (seen_reg == FULL_COUNT) ? seen_reg : seen_reg + CW'(1);
    assign lb1      = 7'(cfg.lookback) + 7'd1;
    assign n_calc   = (32'(lb1) > 32'(seen_inc)) ? seen_inc : CW'(lb1);
    assign quiet    = (pos_reg == '0) || (32'(cfg.lookback) < MIN_LOOKBACK)
                   || (32'(seen_inc) < MIN_SEEN);

    // Scan walks back from the newest entry.
    assign scan_rd   = (state_reg == ST_SCAN) && (cnt_reg != n_reg);
    assign prev_slot = (rd_slot_reg == '0) ? LAST_SLOT : rd_slot_reg - AW'(1);

    assign nn      = (2*CW)'(n_reg) * (2*CW)'(n_reg);
    assign thr_sq  = 32'(cfg.threshold) * 32'(cfg.threshold);
    assign pv_wide = PW'(pv_reg);

    assign ring_we    = (state_reg == ST_DIV_LO);
    assign ring_wdata = '{close: close_reg, typical: typical, volume: vol_reg};

    // Next-state and datapath logic.
    always_comb begin
        state_next   = state_reg;
        slot_next    = slot_reg;
        seen_next    = seen_reg;
        close_next   = close_reg;
        vol_next     = vol_reg;
        pos_next     = pos_reg;
        sum3_next    = sum3_reg;
        q1_next      = q1_reg;
        r1_next      = r1_reg;
        n_next       = n_reg;
        cnt_next     = cnt_reg;
        rd_slot_next = rd_slot_reg;
        c_d_next     = c_d_reg;
        v_d_next     = v_d_reg;
        cc_next      = cc_reg;
        tv_next      = tv_reg;
        sum_c_next   = sum_c_reg;
        sum_v_next   = sum_v_reg;
        sq_next      = sq_reg;
        pv_next      = pv_reg;
        big_next     = big_reg;
        lhs_next     = lhs_reg;
        fire_next    = fire_reg;
        is_mul       = 1'b0;
        mul_a        = '0;
        mul_b        = '0;

        // Read, square and accumulate pipeline of the scan.
        v1_next = scan_rd;
        v2_next = v1_reg;
        if (v1_reg) begin
            c_d_next = ring_rdata.close;
            v_d_next = ring_rdata.volume;
            cc_next  = 64'(ring_rdata.close) * 64'(ring_rdata.close);
            tv_next  = 64'(ring_rdata.typical) * 64'(ring_rdata.volume);
        end
        if (v2_reg) begin
            sum_c_next = sum_c_reg + SUM_W'(c_d_reg);
            sum_v_next = sum_v_reg + SUM_W'(v_d_reg);
            sq_next    = sq_reg + SQ_W'(cc_reg);
            pv_next    = pv_reg + SQ_W'(tv_reg);
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    close_next = candle.close;
                    vol_next   = candle.volume;
                    pos_next   = candle.position;
                    sum3_next  = 34'(candle.high) + 34'(candle.low) + 34'(candle.close);
                    state_next = ST_DIV_HI;
                end
            end
            ST_DIV_HI: begin
                q1_next    = div_q[15:0];
                r1_next    = 2'(div_v - 19'(div_q * 18'd3));
                state_next = ST_DIV_LO;
            end
            ST_DIV_LO: begin
                slot_next    = (slot_reg == LAST_SLOT) ? '0 : slot_reg + AW'(1);
                seen_next    = seen_inc;
                n_next       = n_calc;
                cnt_next     = '0;
                rd_slot_next = slot_reg;
                sum_c_next   = '0;
                sum_v_next   = '0;
                sq_next      = '0;
                pv_next      = '0;
                if (quiet) begin
                    fire_next  = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_rd) begin
                    cnt_next     = cnt_reg + CW'(1);
                    rd_slot_next = prev_slot;
                end
                if ((cnt_reg == n_reg) && !v1_reg && !v2_reg) begin
                    if ((sum_v_reg == '0) || (pv_reg == '0)) begin
                        fire_next  = 1'b0;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_MUL_T;
                    end
                end
            end
            ST_MUL_T: begin
                // n times the sum of squared closes
                is_mul = 1'b1;
                mul_a  = PW'(sq_reg);
                mul_b  = BW'(n_reg);
                if (mul_done) begin
                    big_next   = mul_p;
                    state_next = ST_MUL_U;
                end
            end
            ST_MUL_U: begin
                // Variance numerator, no exit when it is not positive.
                is_mul = 1'b1;
                mul_a  = PW'(sum_c_reg);
                mul_b  = BW'(sum_c_reg);
                if (mul_done) begin
                    if (big_reg <= mul_p) begin
                        fire_next  = 1'b0;
                        state_next = ST_DONE;
                    end else begin
                        big_next   = big_reg - mul_p;
                        state_next = ST_MUL_X;
                    end
                end
            end
            ST_MUL_X: begin
                // Distance of close from the vwap, scaled by total volume.
                is_mul = 1'b1;
                mul_a  = PW'(close_reg);
                mul_b  = BW'(sum_v_reg);
                if (mul_done) begin
                    lhs_next   = (mul_p >= pv_wide) ? mul_p - pv_wide : pv_wide - mul_p;
                    state_next = ST_MUL_L;
                end
            end
            ST_MUL_L: begin
                is_mul = 1'b1;
                mul_a  = lhs_reg;
                mul_b  = BW'(lhs_reg);
                if (mul_done) begin
                    lhs_next   = mul_p;
                    state_next = ST_MUL_L2;
                end
            end
            ST_MUL_L2: begin
                is_mul = 1'b1;
                mul_a  = lhs_reg;
                mul_b  = BW'({nn, 16'b0});
                if (mul_done) begin
                    lhs_next   = mul_p;
                    state_next = ST_MUL_R;
                end
            end
            ST_MUL_R: begin
                is_mul = 1'b1;
                mul_a  = big_reg;
                mul_b  = BW'(thr_sq);
                if (mul_done) begin
                    big_next   = mul_p;
                    state_next = ST_MUL_R2;
                end
            end
            ST_MUL_R2: begin
                is_mul = 1'b1;
                mul_a  = big_reg;
                mul_b  = BW'(sum_v_reg);
                if (mul_done) begin
                    big_next   = mul_p;
                    state_next = ST_MUL_R3;
                end
            end
            ST_MUL_R3: begin
                is_mul = 1'b1;
                mul_a  = big_reg;
                mul_b  = BW'(sum_v_reg);
                if (mul_done) begin
                    fire_next  = (lhs_reg > mul_p);
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // One multiplication is issued per state and finishes with done.
        mul_start   = is_mul && !issued_reg;
        issued_next = mul_done ? 1'b0 : (mul_start ? 1'b1 : issued_reg);
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            issued_reg <= 1'b0;
            slot_reg   <= '0;
            seen_reg   <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            slot_reg   <= slot_next;
            seen_reg   <= seen_next;
            v1_reg     <= v1_next;
            v2_reg     <= v2_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        close_reg   <= close_next;
        vol_reg     <= vol_next;
        pos_reg     <= pos_next;
        sum3_reg    <= sum3_next;
        q1_reg      <= q1_next;
        r1_reg      <= r1_next;
        n_reg       <= n_next;
        cnt_reg     <= cnt_next;
        rd_slot_reg <= rd_slot_next;
        c_d_reg     <= c_d_next;
        v_d_reg     <= v_d_next;
        cc_reg      <= cc_next;
        tv_reg      <= tv_next;
        sum_c_reg   <= sum_c_next;
        sum_v_reg   <= sum_v_next;
        sq_reg      <= sq_next;
        pv_reg      <= pv_next;
        big_reg     <= big_next;
        lhs_reg     <= lhs_next;
        fire_reg    <= fire_next;
    end

    assign ready         = (state_reg == ST_IDLE);
    assign res_valid     = (state_reg == ST_DONE);
    assign res.exit_now  = fire_reg;
    assign res.close_qty = fire_reg ? pos_reg : '0;

endmodule

// ===== sv/rolling_vwap_zscore_stop.sv =====
// Top level of the rolling VWAP z-score stop: stream ports, register port, result register.
//
// Each input item is one candle with the open position; each yields exactly one result
// item with exit_now on m_tuser and the quantity to close on m_tdata.
// The candle is written into a history memory, then the newest n candles
// (n = min(lookback+1, candles seen, MAX_WINDOW)) are read back one per cycle to form
// the volume and price sums. The squared z-score test then runs up to eight products on a
// shift-add multiplier that handles one multiplier bit per cycle up to its highest set bit.
// When an item cannot fire (flat position, short lookback, fewer than three candles),
// its result is valid once the two division states are done, with no scan and no
// products, and the next item is accepted when the sequencer is back in idle.
// Otherwise the time of an item is set by n and by the multiplier. One item is in work at a time.
// s_tready is high while the sequencer is idle. The result waits in an output register,
// so a new candle is taken while m_tready is low; a finished result waits for that
// register to free. Reset clears the write pointer, the candle count and the
// registers (lookback 20, threshold 2.0); the history memory is not cleared, since
// no entry is read before it is written.
// Registers: lookback at byte address 0, threshold (Q8.8) at byte address 4.
module rolling_vwap_zscore_stop #(
    parameter int MAX_WINDOW = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // high_price, low_price, close_price, volume, position_qty
    input  logic [159:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // close_qty
    output logic [31:0]  m_tdata,
    // exit_now
    output logic         m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic REG_LOOKBACK  = 1'b0;
    localparam logic REG_THRESHOLD = 1'b1;

    logic [5:0]         lookback_reg, lookback_next;
    logic [15:0]        threshold_reg, threshold_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [31:0]        m_tdata_reg, m_tdata_next;
    logic               m_tuser_reg, m_tuser_next;

    logic               cfg_wr;
    rvz_pkg::cfg_t      cfg;
    rvz_pkg::candle_t   candle;
    logic               core_ready;
    logic               res_valid;
    logic               res_ready;
    rvz_pkg::result_t   res;

    assign candle.high     = s_tdata[31:0];
    assign candle.low      = s_tdata[63:32];
    assign candle.close    = s_tdata[95:64];
    assign candle.volume   = s_tdata[127:96];
    assign candle.position = s_tdata[159:128];

    assign cfg.lookback  = lookback_reg;
    assign cfg.threshold = threshold_reg;

    rvz_core #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .start     (s_tvalid && core_ready),
        .candle    (candle),
        .ready     (core_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign s_tready  = core_ready;
    assign res_ready = !m_tvalid_reg || m_tready;

    // Register writes.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        lookback_next  = lookback_reg;
        threshold_next = threshold_reg;
        if (cfg_wr) begin
            unique case (paddr[2])
                REG_LOOKBACK:  lookback_next  = pwdata[5:0];
                REG_THRESHOLD: threshold_next = pwdata[15:0];
                default: begin
                    lookback_next = lookback_reg;
                end
            endcase
        end
    end

    // Register reads.
    always_comb begin
        unique case (paddr[2])
            REG_LOOKBACK:  prdata = {26'b0, lookback_reg};
            REG_THRESHOLD: prdata = {16'b0, threshold_reg};
            default:       prdata = '0;
        endcase
    end

    // Output register.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = res.close_qty;
            m_tuser_next  = res.exit_now;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lookback_reg  <= rvz_pkg::LOOKBACK_RST;
            threshold_reg <= rvz_pkg::THRESHOLD_RST;
            m_tvalid_reg  <= 1'b0;
        end else begin
            lookback_reg  <= lookback_next;
            threshold_reg <= threshold_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
